// ----- src/wbps_pkg.sv -----
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants for the byte pattern scanner
// Register indexes, search mode codes, field widths and the mode control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

  localparam int DATA_BITS       = 8;
  localparam int CFG_DATA_BITS   = 64;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int LENGTH_BITS     = 6;
  localparam int MODE_BITS       = 2;
  localparam int PAT_REG_COUNT   = 4;
  localparam int PAT_STORE_BYTES = PAT_REG_COUNT * CFG_DATA_BITS / DATA_BITS;
  localparam int PAT_INDEX_BITS  = $clog2(PAT_STORE_BYTES);

  // byte that matches anything in the wildcard modes
  localparam logic [DATA_BITS-1:0] ANY_BYTE = 8'h3F;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAT_0_7   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAT_8_15  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAT_16_23 = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAT_24_31 = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE      = 3'd5;

  // search modes
  localparam logic [MODE_BITS-1:0] MODE_WILD_ALL   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_EXACT_ALL  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_WILD_FIRST = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_OFF        = 2'd3;

  typedef struct packed {
    logic wild;        // '?' pattern bytes match anything
    logic enabled;     // matching active at all
    logic first_only;  // one match per region
  } mode_ctl_t;

endpackage

`default_nettype wire

// ----- src/wbps_if.sv -----
// ----------------------------------------------------------------------------
// wbps_if: stream channels of the byte pattern scanner
// Input byte channel and match address channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbps_in_if #(
  parameter int ADDRESS_BITS = 47
);
  logic                           valid;
  logic                           ready;
  logic [wbps_pkg::DATA_BITS-1:0] data_byte;
  logic                           first_of_region;
  logic [ADDRESS_BITS-1:0]        region_base;

  modport source (output valid, data_byte, first_of_region, region_base, input ready);
  modport sink   (input valid, data_byte, first_of_region, region_base, output ready);
endinterface

interface wbps_out_if #(
  parameter int ADDRESS_BITS = 47
);
  logic                    valid;
  logic                    ready;
  logic [ADDRESS_BITS-1:0] match_address;

  modport source (output valid, match_address, input ready);
  modport sink   (input valid, match_address, output ready);
endinterface

`default_nettype wire

// ----- src/wbps_cfg.sv -----
// ----------------------------------------------------------------------------
// wbps_cfg: configuration registers and pattern alignment
// Holds the pattern, length and mode; registers the pattern reversed against
// the window (newest byte first) with a use mask, plus the clamped length.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cfg #(
  parameter int MAX_PATTERN = 32,
  parameter int LEN_BITS    = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write_enable,
  input  wire logic [wbps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [wbps_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic [MAX_PATTERN-1:0][wbps_pkg::DATA_BITS-1:0] aligned,
  output logic [MAX_PATTERN-1:0]                     mask,
  output logic [LEN_BITS-1:0]                        len_eff,
  output wbps_pkg::mode_ctl_t                        ctl
);

  logic [wbps_pkg::PAT_REG_COUNT-1:0][wbps_pkg::CFG_DATA_BITS-1:0] pat_reg;
  logic [wbps_pkg::LENGTH_BITS-1:0] pattern_length;
  logic [wbps_pkg::MODE_BITS-1:0]   search_mode;

  logic [wbps_pkg::PAT_STORE_BYTES-1:0][wbps_pkg::DATA_BITS-1:0] pat_byte;
  logic [MAX_PATTERN-1:0][wbps_pkg::DATA_BITS-1:0] aligned_next;
  logic [MAX_PATTERN-1:0]                          mask_next;
  logic [LEN_BITS-1:0]                             len_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_reg        <= '0;
      pattern_length <= wbps_pkg::LENGTH_BITS'(1);
      search_mode    <= wbps_pkg::MODE_WILD_ALL;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        wbps_pkg::REG_PAT_0_7:   pat_reg[0] <= cfg_data;
        wbps_pkg::REG_PAT_8_15:  pat_reg[1] <= cfg_data;
        wbps_pkg::REG_PAT_16_23: pat_reg[2] <= cfg_data;
        wbps_pkg::REG_PAT_24_31: pat_reg[3] <= cfg_data;
        wbps_pkg::REG_LENGTH:    pattern_length <= cfg_data[wbps_pkg::LENGTH_BITS-1:0];
        wbps_pkg::REG_MODE:      search_mode <= cfg_data[wbps_pkg::MODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // byte 0 sits in the low bits of register 0
  assign pat_byte = pat_reg;

  always_comb begin
    int idx;
    if (int'(pattern_length) > MAX_PATTERN) begin
      len_next = LEN_BITS'(MAX_PATTERN);
    end else begin
      len_next = LEN_BITS'(pattern_length);
    end
    // window slot k holds the byte that pattern byte len-1-k must match
    for (int k = 0; k < MAX_PATTERN; k++) begin
      idx             = int'(len_next) - 1 - k;
      mask_next[k]    = (k < int'(len_next));
      aligned_next[k] = '0;
      if (k < int'(len_next) && idx < wbps_pkg::PAT_STORE_BYTES) begin
        aligned_next[k] = pat_byte[idx[wbps_pkg::PAT_INDEX_BITS-1:0]];
      end
    end
  end

  // the user must change config only while idle (the block does not enforce it),
  // so these output registers are hidden behind the input register of the scan pipeline
  always_ff @(posedge clk) begin
    aligned <= aligned_next;
    mask    <= mask_next;
    len_eff <= len_next;
  end

  assign ctl.wild       = search_mode inside {wbps_pkg::MODE_WILD_ALL,
                                              wbps_pkg::MODE_WILD_FIRST};
  assign ctl.enabled    = (search_mode != wbps_pkg::MODE_OFF);
  assign ctl.first_only = (search_mode == wbps_pkg::MODE_WILD_FIRST);

endmodule

`default_nettype wire

// ----- src/wbps_scan.sv -----
// ----------------------------------------------------------------------------
// wbps_scan: byte window, restart counter, address tracking and compare
// On each step shifts in one byte, compares the window with the aligned
// pattern and updates the scan state.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_scan #(
  parameter int MAX_PATTERN  = 32,
  parameter int ADDRESS_BITS = 47,
  parameter int LEN_BITS     = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  step,
  input  wire logic [wbps_pkg::DATA_BITS-1:0]        data_byte,
  input  wire logic                                  first_of_region,
  input  wire logic [ADDRESS_BITS-1:0]               region_base,
  input  wire logic [MAX_PATTERN-1:0][wbps_pkg::DATA_BITS-1:0] aligned,
  input  wire logic [MAX_PATTERN-1:0]                mask,
  input  wire logic [LEN_BITS-1:0]                   len_eff,
  input  wire wbps_pkg::mode_ctl_t                   ctl,
  output logic                                       hit,
  output logic [ADDRESS_BITS-1:0]                    match_address
);

  logic [MAX_PATTERN-1:0][wbps_pkg::DATA_BITS-1:0] byte_window;
  logic [MAX_PATTERN-1:0][wbps_pkg::DATA_BITS-1:0] byte_window_next;
  logic [LEN_BITS-1:0]     bytes_since_restart;
  logic [LEN_BITS-1:0]     count_now;
  logic                    region_done;
  logic                    done_now;
  logic [ADDRESS_BITS-1:0] next_addr;   // address of the next byte
  logic [ADDRESS_BITS-1:0] this_addr;
  logic [MAX_PATTERN-1:0]  slot_ok;

  always_comb begin
    byte_window_next[0] = data_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      byte_window_next[k] = first_of_region ? '0 : byte_window[k-1];
    end
  end

  always_comb begin
    if (first_of_region) begin
      count_now = LEN_BITS'(1);
    end else if (bytes_since_restart == LEN_BITS'(MAX_PATTERN)) begin
      count_now = bytes_since_restart;
    end else begin
      count_now = bytes_since_restart + LEN_BITS'(1);
    end
  end

  assign done_now  = first_of_region ? 1'b0 : region_done;
  assign this_addr = first_of_region ? region_base : next_addr;

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      slot_ok[k] = !mask[k] || (byte_window_next[k] == aligned[k]) ||
                   (ctl.wild && aligned[k] == wbps_pkg::ANY_BYTE);
    end
  end

  assign hit = ctl.enabled && (len_eff != '0) && !done_now &&
               (count_now >= len_eff) && (&slot_ok);

  // start of the match: current byte address minus (len - 1)
  assign match_address = this_addr - ADDRESS_BITS'(len_eff) + ADDRESS_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_window         <= '0;
      bytes_since_restart <= '0;
      region_done         <= 1'b0;
      next_addr           <= '0;
    end else if (step) begin
      byte_window         <= byte_window_next;
      bytes_since_restart <= hit ? '0 : count_now;
      region_done         <= done_now | (hit & ctl.first_only);
      next_addr           <= this_addr + ADDRESS_BITS'(1);
    end
  end

endmodule

`default_nettype wire

// ----- src/wildcard_byte_pattern_scan.sv -----
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan: streaming wildcard byte pattern matcher
// Scans a byte stream grouped into regions for a 1..MAX_PATTERN byte pattern
// and reports each non-overlapping match's start address (mode 2: first only).
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  --------  ---  -------------  ----------------------------------------------
//  scan_in   in   valid / ready  data_byte, first_of_region, region_base
//  scan_out  out  valid / ready  match_address (zero or one per input byte)
//  cfg_*     in   write enable   cfg_index, cfg_data (6 registers, no read-back)
//
//  One byte per cycle sustained while scan_out accepts results. A byte moves
//  from the input transaction through the input register, then the window
//  compare into the result register. Reset (rst, synchronous) clears the window,
//  counters and both valid flags; config returns to length 1, mode 0, pattern 0.
//  A stalled result holds its register; the held input byte waits behind it
//  and scan_in stalls while the input register is full and cannot move on.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_scan #(
  parameter int MAX_PATTERN  = 32,
  parameter int ADDRESS_BITS = 47
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  wbps_in_if.sink                                  scan_in,
  wbps_out_if.source                               scan_out,
  input  wire logic                                cfg_write_enable,
  input  wire logic [wbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [wbps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);

  // config view
  logic [MAX_PATTERN-1:0][wbps_pkg::DATA_BITS-1:0] aligned;
  logic [MAX_PATTERN-1:0] mask;
  logic [LEN_BITS-1:0]    len_eff;
  wbps_pkg::mode_ctl_t    ctl;

  // input register
  logic                           in_valid;
  logic [wbps_pkg::DATA_BITS-1:0] in_byte;
  logic                           in_first;
  logic [ADDRESS_BITS-1:0]        in_base;

  // result register
  logic                    out_valid;
  logic [ADDRESS_BITS-1:0] out_address;

  logic                    advance;
  logic                    hit;
  logic [ADDRESS_BITS-1:0] hit_address;

  wbps_cfg #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_BITS    (LEN_BITS)
  ) u_cfg (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .aligned          (aligned),
    .mask             (mask),
    .len_eff          (len_eff),
    .ctl              (ctl)
  );

  // held byte moves on when the result slot is free or emptying this cycle
  assign advance       = in_valid && (!out_valid || scan_out.ready);
  assign scan_in.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (scan_in.ready) begin
      in_valid <= scan_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_in.valid && scan_in.ready) begin
      in_byte  <= scan_in.data_byte;
      in_first <= scan_in.first_of_region;
      in_base  <= scan_in.region_base;
    end
  end

  wbps_scan #(
    .MAX_PATTERN  (MAX_PATTERN),
    .ADDRESS_BITS (ADDRESS_BITS),
    .LEN_BITS     (LEN_BITS)
  ) u_scan (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .data_byte       (in_byte),
    .first_of_region (in_first),
    .region_base     (in_base),
    .aligned         (aligned),
    .mask            (mask),
    .len_eff         (len_eff),
    .ctl             (ctl),
    .hit             (hit),
    .match_address   (hit_address)
  );

  // a byte without a match leaves the result slot empty
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hit;
    end else if (scan_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      out_address <= hit_address;
    end
  end

  assign scan_out.valid         = out_valid;
  assign scan_out.match_address = out_address;

endmodule

`default_nettype wire
